// ===== design/hpnw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpnw_pkg: shared types and constants of the point normalize and weld block
// Beat structures of both channels, register indexes and cell control.
// ----------------------------------------------------------------------------
package hpnw_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_SCALE_X = 3'd0;
  localparam logic [2:0] REG_SCALE_Y = 3'd1;
  localparam logic [2:0] REG_SCALE_Z = 3'd2;
  localparam logic [2:0] REG_TARGET  = 3'd3;
  localparam logic [2:0] REG_WELD    = 3'd4;

  // Unity in unsigned Q1.16.
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic               last_vertex;
    logic               no_vertex;
  } in_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [16:0]        norm_scale;
    logic               last_point;
    logic               set_empty;
    logic               points_dropped;
  } out_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== design/hpnw_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpnw_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hpnw_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/hpnw_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpnw_div: serial restoring divider
// Unsigned quotient, one bit per cycle, after a start pulse.
// ----------------------------------------------------------------------------
module hpnw_div #(
  parameter int NW = 47,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   den_r;
  logic [DW:0]     trial;
  logic            fits;
  logic [DW:0]     rem_next;

  always_comb begin
    trial    = {rem, quo[NW-1]};
    fits     = trial >= {1'b0, den_r};
    rem_next = fits ? trial - {1'b0, den_r} : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        quo   <= num;
        den_r <= den;
      end else if (busy) begin
        quo <= {quo[NW-2:0], fits};
        rem <= rem_next[DW-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/hpnw_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpnw_cell: one weld cell of the kept point row
// Holds one kept point, checks passing candidates against it, and takes the
// first candidate that reaches it empty and unwelded.
// ----------------------------------------------------------------------------
module hpnw_cell #(
  parameter int CW = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  hpnw_pkg::cell_ctrl_t   ctrl,
  input  logic [15:0]            weld,
  input  logic [31:0]            w2,
  input  logic                   in_v,
  input  logic                   in_dup,
  input  logic [3*CW-1:0]        in_q,
  output logic                   out_v,
  output logic                   out_dup,
  output logic [3*CW-1:0]        out_q,
  input  logic                   nb_kv,
  input  logic [3*CW-1:0]        nb_kq,
  output logic                   kv,
  output logic [3*CW-1:0]        kq
);

  logic signed [CW:0] dif [3];
  logic [CW:0]        mag [3];
  logic [2:0]         far;
  logic [31:0]        sq [3];
  logic [33:0]        dsum;
  logic               near;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dif[a] = (CW+1)'($signed(in_q[a*CW +: CW])) - (CW+1)'($signed(kq[a*CW +: CW]));
      mag[a] = dif[a][CW] ? (CW+1)'(-dif[a]) : (CW+1)'(dif[a]);
      far[a] = mag[a] >= (CW+1)'(weld);
      sq[a]  = mag[a][15:0] * mag[a][15:0];
    end
    dsum = 34'(sq[0]) + 34'(sq[1]) + 34'(sq[2]);
    near = kv && (far == 3'b000) && (dsum < 34'(w2));
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      kv    <= 1'b0;
      out_v <= 1'b0;
    end else if (ctrl.shift) begin
      kv    <= nb_kv;
      kq    <= nb_kq;
      out_v <= 1'b0;
    end else begin
      out_v   <= in_v && kv;
      out_dup <= in_dup | near;
      out_q   <= in_q;
      if (in_v && !kv && !in_dup) begin
        kv <= 1'b1;
        kq <= in_q;
      end
    end
  end

endmodule

// ===== design/hull_point_normalize_weld.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hull_point_normalize_weld: center, normalize and weld a point cloud
// Loads scaled vertices, then emits centered, normalized, welded points.
// ----------------------------------------------------------------------------
// Usage:
// Vertices arrive on the input channel, one beat per cycle while loading.
// Each vertex is scaled per axis; vertices whose scaled value leaves the
// coordinate range are skipped, and vertices beyond MAX_POINTS are dropped
// and flagged. The beat marked last_vertex ends the run: the input channel
// then holds ready low until every result beat of the run has been loaded
// into the output register.
// End of run: three serial divisions for the centroids, plus a fourth for
// the scale when the largest extent exceeds the target, each in the
// shared divider, then one store read per point, then a drain while the
// last candidate crosses the weld cell row.
// Results then leave at one beat per cycle out of the cell row, slowed
// only by the receiver: a stalled result stays in the output register and
// the row holds still. An empty run gives one beat flagged set_empty.
// Reset clears all run state and sets the registers to their defaults.
// The user writes configuration only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module hull_point_normalize_weld #(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  hpnw_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output hpnw_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data
);

  localparam int CW    = COORD_WIDTH;
  localparam int NCW   = $clog2(MAX_POINTS + 1);
  localparam int AW    = MAX_POINTS > 1 ? $clog2(MAX_POINTS) : 1;
  localparam int SW    = CW + NCW;
  localparam int QW    = SW > 47 ? SW : 47;
  localparam int PW    = CW + 19;
  localparam int DRW   = $clog2(MAX_POINTS + 3);

  localparam logic signed [47:0] CMAX48 = {{(49-CW){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [47:0] CMIN48 = {{(49-CW){1'b1}}, {(CW-1){1'b0}}};
  localparam logic signed [CW+2:0] QMAX = {4'b0000, {(CW-1){1'b1}}};
  localparam logic signed [CW+2:0] QMIN = {4'b1111, {(CW-1){1'b0}}};

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_FIN   = 3'd1;
  localparam logic [2:0] S_EMPTY = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_NORM  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  // Configuration registers.
  logic signed [31:0] scale [3];
  logic [30:0]        target_size;
  logic [15:0]        weld_distance;
  logic [31:0]        w2;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale[0]      <= 32'sd65536;
      scale[1]      <= 32'sd65536;
      scale[2]      <= 32'sd65536;
      target_size   <= 31'd655360;
      weld_distance <= 16'd7;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hpnw_pkg::REG_SCALE_X: scale[0] <= cfg_data;
        hpnw_pkg::REG_SCALE_Y: scale[1] <= cfg_data;
        hpnw_pkg::REG_SCALE_Z: scale[2] <= cfg_data;
        hpnw_pkg::REG_TARGET:  target_size <= cfg_data[30:0];
        hpnw_pkg::REG_WELD:    weld_distance <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // The user changes the squared weld radius only while the block is idle; nothing enforces this.
  always_ff @(posedge clk) begin
    w2 <= weld_distance * weld_distance;
  end

  logic [2:0] state;
  logic       accept;
  logic       run_clr;

  // Load stage one: the per-axis scale products.
  logic               m1_v;
  logic               m1_last;
  logic               m1_nov;
  logic signed [63:0] m1_p [3];
  logic signed [63:0] prod [3];

  assign in_ready = (state == S_LOAD) && !(m1_v && m1_last);
  assign accept   = in_valid && in_ready;
  assign prod[0]  = in_data.vertex_x * scale[0];
  assign prod[1]  = in_data.vertex_y * scale[1];
  assign prod[2]  = in_data.vertex_z * scale[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else begin
      m1_v <= accept;
    end
    if (accept) begin
      m1_last <= in_data.last_vertex;
      m1_nov  <= in_data.no_vertex;
      for (int a = 0; a < 3; a++) begin
        m1_p[a] <= prod[a];
      end
    end
  end

  // Load stage two: range test, then store, sum and bounding box.
  logic signed [47:0]   p48 [3];
  logic signed [CW-1:0] pc [3];
  logic                 in_range;
  logic                 keep;
  logic                 store;
  logic [NCW-1:0]       point_count;
  logic signed [SW-1:0] sum [3];
  logic signed [CW-1:0] box_lo [3];
  logic signed [CW-1:0] box_hi [3];
  logic                 overflow_seen;

  always_comb begin
    in_range = 1'b1;
    for (int a = 0; a < 3; a++) begin
      p48[a] = $signed(m1_p[a][63:16]);
      pc[a]  = p48[a][CW-1:0];
      if (p48[a] > CMAX48 || p48[a] < CMIN48) begin
        in_range = 1'b0;
      end
    end
    keep  = m1_v && !m1_nov && in_range;
    store = keep && (point_count < NCW'(MAX_POINTS));
  end

  always_ff @(posedge clk) begin
    if (rst || run_clr) begin
      point_count   <= '0;
      overflow_seen <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        sum[a]    <= '0;
        box_lo[a] <= CMAX48[CW-1:0];
        box_hi[a] <= CMIN48[CW-1:0];
      end
    end else if (state == S_LOAD && keep) begin
      if (store) begin
        point_count <= point_count + 1'b1;
        for (int a = 0; a < 3; a++) begin
          sum[a] <= sum[a] + SW'(pc[a]);
          if (pc[a] < box_lo[a]) begin
            box_lo[a] <= pc[a];
          end
          if (pc[a] > box_hi[a]) begin
            box_hi[a] <= pc[a];
          end
        end
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  // Point store.
  logic              ram_re;
  logic [NCW-1:0]    rd_i;
  logic [3*CW-1:0]   ram_q;

  hpnw_ram #(
    .WIDTH (3 * CW),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (state == S_LOAD && store),
    .waddr (point_count[AW-1:0]),
    .wdata ({pc[2], pc[1], pc[0]}),
    .re    (ram_re),
    .raddr (rd_i[AW-1:0]),
    .rdata (ram_q)
  );

  // Largest box extent; boxes are never inverted once a point is stored.
  logic signed [CW:0] span [3];
  logic [CW-1:0]      ext_comb;
  logic [CW-1:0]      ext;

  always_comb begin
    ext_comb = '0;
    for (int a = 0; a < 3; a++) begin
      span[a] = (CW+1)'(box_hi[a]) - (CW+1)'(box_lo[a]);
      if (!span[a][CW] && span[a][CW-1:0] > ext_comb) begin
        ext_comb = span[a][CW-1:0];
      end
    end
  end

  // Shared divider for the centroids and the normalize scale.
  logic          div_go;
  logic [QW-1:0] div_num;
  logic [CW-1:0] div_den;
  logic          div_done;
  logic [QW-1:0] div_q;
  logic [1:0]    div_idx;
  logic [SW-1:0] sum_abs [3];
  logic          big;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum_abs[a] = sum[a][SW-1] ? SW'(-sum[a]) : SW'(sum[a]);
    end
    big = 64'(ext) > 64'(target_size);
  end

  hpnw_div #(
    .NW (QW),
    .DW (CW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  logic signed [CW-1:0] cen [3];
  logic [16:0]          sc;
  logic [DRW-1:0]       drain_cnt;

  // Output side signals used by the sequencer.
  logic               out_free;
  logic               kv [MAX_POINTS+1];
  logic [3*CW-1:0]    kq [MAX_POINTS+1];
  logic               emit_load;
  logic               empty_load;

  assign out_free   = !out_valid || out_ready;
  assign emit_load  = (state == S_EMIT) && out_free && kv[0];
  assign empty_load = (state == S_EMPTY) && out_free;
  assign run_clr    = empty_load || (state == S_EMIT && !kv[0]);
  assign ram_re     = (state == S_NORM);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      div_go  <= 1'b0;
      div_idx <= '0;
      rd_i    <= '0;
      drain_cnt <= '0;
    end else begin
      div_go <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (m1_v && m1_last) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (point_count == '0) begin
            state <= S_EMPTY;
          end else begin
            ext     <= ext_comb;
            div_num <= QW'(sum_abs[0]);
            div_den <= CW'(point_count);
            div_go  <= 1'b1;
            div_idx <= 2'd0;
            state   <= S_DIV;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            state <= S_LOAD;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (div_idx == 2'd3) begin
              sc    <= div_q[16:0];
              rd_i  <= '0;
              state <= S_NORM;
            end else begin
              cen[div_idx] <= sum[div_idx][SW-1] ? CW'(-div_q[CW-1:0]) : div_q[CW-1:0];
              if (div_idx == 2'd2) begin
                if (big) begin
                  div_num <= QW'({target_size, 16'h0000});
                  div_den <= ext;
                  div_go  <= 1'b1;
                  div_idx <= 2'd3;
                end else begin
                  sc    <= hpnw_pkg::ONE_Q16;
                  rd_i  <= '0;
                  state <= S_NORM;
                end
              end else begin
                div_num <= QW'(sum_abs[div_idx + 2'd1]);
                div_den <= CW'(point_count);
                div_go  <= 1'b1;
                div_idx <= div_idx + 2'd1;
              end
            end
          end
        end
        S_NORM: begin
          rd_i <= rd_i + 1'b1;
          if (rd_i == point_count - 1'b1) begin
            drain_cnt <= '0;
            state     <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          drain_cnt <= drain_cnt + 1'b1;
          if (drain_cnt == DRW'(MAX_POINTS + 2)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!kv[0]) begin
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // Normalize pipeline: read data, then center and scale, then saturate.
  logic                 rd_v;
  logic                 pv;
  logic signed [CW:0]   dd [3];
  logic signed [PW-1:0] pr [3];
  logic signed [CW+2:0] tq [3];
  logic [3*CW-1:0]      cand_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dd[a] = (CW+1)'($signed(ram_q[a*CW +: CW])) - (CW+1)'(cen[a]);
      tq[a] = $signed(pr[a][PW-1:16]);
      if (tq[a] > QMAX) begin
        cand_q[a*CW +: CW] = QMAX[CW-1:0];
      end else if (tq[a] < QMIN) begin
        cand_q[a*CW +: CW] = QMIN[CW-1:0];
      end else begin
        cand_q[a*CW +: CW] = tq[a][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      pv   <= 1'b0;
    end else begin
      rd_v <= ram_re;
      pv   <= rd_v;
    end
    for (int a = 0; a < 3; a++) begin
      pr[a] <= dd[a] * $signed({1'b0, sc});
    end
  end

  // Weld cell row. Candidates walk right; kept points shift left to emit.
  hpnw_pkg::cell_ctrl_t ctrl;
  logic            c_v   [MAX_POINTS+1];
  logic            c_dup [MAX_POINTS+1];
  logic [3*CW-1:0] c_q   [MAX_POINTS+1];

  assign ctrl.shift = emit_load;
  assign ctrl.clear = run_clr;
  assign c_v[0]     = pv;
  assign c_dup[0]   = 1'b0;
  assign c_q[0]     = cand_q;
  assign kv[MAX_POINTS] = 1'b0;
  assign kq[MAX_POINTS] = '0;

  for (genvar j = 0; j < MAX_POINTS; j++) begin : g_cell
    hpnw_cell #(
      .CW (CW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .weld    (weld_distance),
      .w2      (w2),
      .in_v    (c_v[j]),
      .in_dup  (c_dup[j]),
      .in_q    (c_q[j]),
      .out_v   (c_v[j+1]),
      .out_dup (c_dup[j+1]),
      .out_q   (c_q[j+1]),
      .nb_kv   (kv[j+1]),
      .nb_kq   (kq[j+1]),
      .kv      (kv[j]),
      .kq      (kq[j])
    );
  end

  // Output register.
  hpnw_pkg::out_t beat;

  always_comb begin
    beat.center_x       = 32'(cen[0]);
    beat.center_y       = 32'(cen[1]);
    beat.center_z       = 32'(cen[2]);
    beat.point_x        = 32'($signed(kq[0][0 +: CW]));
    beat.point_y        = 32'($signed(kq[0][CW +: CW]));
    beat.point_z        = 32'($signed(kq[0][2*CW +: CW]));
    beat.norm_scale     = sc;
    beat.last_point     = !kv[1];
    beat.set_empty      = 1'b0;
    beat.points_dropped = overflow_seen;
    if (state == S_EMPTY) begin
      beat.center_x   = '0;
      beat.center_y   = '0;
      beat.center_z   = '0;
      beat.point_x    = '0;
      beat.point_y    = '0;
      beat.point_z    = '0;
      beat.norm_scale = hpnw_pkg::ONE_Q16;
      beat.last_point = 1'b1;
      beat.set_empty  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load || empty_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (emit_load || empty_load) begin
      out_data <= beat;
    end
  end

endmodule

// ===== design/hpnw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpnw_checker: port level checks of the point normalize and weld block
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module hpnw_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input hpnw_pkg::out_t out_data
);

  // A stalled result beat stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // An empty result is always marked as the final beat of its run.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.set_empty |-> out_data.last_point)
    else $error("empty result not marked last");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.set_empty |->
      out_data.norm_scale == hpnw_pkg::ONE_Q16 && out_data.point_x == '0 &&
      out_data.center_x == '0)
    else $error("empty result fields wrong");

  // Normalization never enlarges.
  a_scale: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.norm_scale <= hpnw_pkg::ONE_Q16)
    else $error("norm scale above one");

endmodule

bind hull_point_normalize_weld hpnw_checker u_hpnw_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== dv/hull_point_normalize_weld_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hull_point_normalize_weld_tb: self-checking bench of the normalize and weld block
// Meshes of scaled vertices are sent through a valid/ready driver, and each
// result beat is checked against a software copy of the centering,
// normalizing and welding pass. Registers change between meshes.
// ----------------------------------------------------------------------------
module hull_point_normalize_weld_tb;

  localparam int MAXP  = 64;
  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  hpnw_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hpnw_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = hpnw_pkg::REG_SCALE_X;
  logic [31:0] cfg_data = '0;

  always #5 clk = ~clk;

  hull_point_normalize_weld dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the registers and of the run state.
  longint scl [3];
  longint tgt_size;
  longint weld_dist;
  longint pts [MAXP][3];
  longint kept [MAXP][3];
  int     n_pts;
  longint sums [3];
  longint lo [3];
  longint hi [3];
  bit     lost_points;

  hpnw_pkg::in_t  vertex_queue [$];
  hpnw_pkg::out_t expected_points [$];

  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int meshes = 0;
  int idle_cycles = 0;

  function automatic longint floor16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint div_zero(longint s, int n);
    longint m;
    m = (s < 0) ? -s : s;
    m = m / n;
    return (s < 0) ? -m : m;
  endfunction

  function automatic longint clamp_coord(longint v);
    return (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
  endfunction

  task automatic clear_mesh();
    n_pts = 0;
    lost_points = 0;
    for (int a = 0; a < 3; a++) begin
      sums[a] = 0;
      lo[a] = CMAX;
      hi[a] = CMIN;
    end
  endtask

  task automatic add_vertex(hpnw_pkg::in_t b);
    vertex_queue = {vertex_queue, b};
  endtask

  task automatic push_result(longint p [3], longint c [3], longint sc, bit lst, bit emp);
    hpnw_pkg::out_t r;
    r.point_x = p[0][31:0];
    r.point_y = p[1][31:0];
    r.point_z = p[2][31:0];
    r.center_x = c[0][31:0];
    r.center_y = c[1][31:0];
    r.center_z = c[2][31:0];
    r.norm_scale = sc[16:0];
    r.last_point = lst;
    r.set_empty = emp;
    r.points_dropped = lost_points;
    expected_points = {expected_points, r};
  endtask

  // Works out the results that one accepted input beat causes.
  task automatic predict_weld(hpnw_pkg::in_t b);
    longint p [3];
    longint c [3];
    longint q [3];
    longint ext, sc, w2, m, sq_sum;
    int nk;
    bit fits, dup, near;
    if (!b.no_vertex) begin
      fits = 1;
      p[0] = floor16(longint'(b.vertex_x) * scl[0]);
      p[1] = floor16(longint'(b.vertex_y) * scl[1]);
      p[2] = floor16(longint'(b.vertex_z) * scl[2]);
      for (int a = 0; a < 3; a++)
        if (p[a] > CMAX || p[a] < CMIN) fits = 0;
      if (fits) begin
        if (n_pts >= MAXP) begin
          lost_points = 1;
        end else begin
          for (int a = 0; a < 3; a++) begin
            pts[n_pts][a] = p[a];
            if (p[a] < lo[a]) lo[a] = p[a];
            if (p[a] > hi[a]) hi[a] = p[a];
            sums[a] += p[a];
          end
          n_pts++;
        end
      end
    end
    if (!b.last_vertex) return;
    meshes++;
    if (n_pts == 0) begin
      for (int a = 0; a < 3; a++) c[a] = 0;
      push_result(c, c, 65536, 1, 1);
      clear_mesh();
      return;
    end
    ext = 0;
    for (int a = 0; a < 3; a++) begin
      c[a] = div_zero(sums[a], n_pts);
      if (hi[a] - lo[a] > ext) ext = hi[a] - lo[a];
    end
    sc = 65536;
    if (ext > tgt_size) sc = (tgt_size << 16) / ext;
    w2 = weld_dist * weld_dist;
    nk = 0;
    for (int i = 0; i < n_pts; i++) begin
      dup = 0;
      for (int a = 0; a < 3; a++) begin
        m = pts[i][a] - c[a];
        q[a] = clamp_coord(sc == 65536 ? m : floor16(m * sc));
      end
      for (int k = 0; k < nk && !dup; k++) begin
        sq_sum = 0;
        near = 1;
        for (int a = 0; a < 3; a++) begin
          m = q[a] - kept[k][a];
          if (m < 0) m = -m;
          if (near && m >= weld_dist) near = 0;
          if (near) sq_sum += m * m;
        end
        if (near && sq_sum < w2) dup = 1;
      end
      if (!dup && nk < MAXP) begin
        for (int a = 0; a < 3; a++) kept[nk][a] = q[a];
        nk++;
      end
    end
    for (int k = 0; k < nk; k++) begin
      for (int a = 0; a < 3; a++) p[a] = kept[k][a];
      push_result(p, c, sc, k + 1 == nk, 0);
    end
    clear_mesh();
  endtask

  // Driver: each beat waits a random number of cycles before valid rises.
  int in_wait = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_weld(in_data);
        beats_in++;
        in_wait = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) in_wait = 0;
      end
      if (!(in_valid && !in_ready)) begin
        if (in_wait > 0) begin
          in_wait--;
          in_valid <= 1'b0;
        end else if (vertex_queue.size() > 0) begin
          in_data <= vertex_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result beat and stalls the receiver at random.
  int out_wait = 0;
  always @(posedge clk) begin
    hpnw_pkg::out_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        beats_out++;
        if (expected_points.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %p", out_data);
        end else begin
          e = expected_points.pop_front();
          if (e !== out_data) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", e, out_data);
          end
        end
        out_wait = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) out_wait = 0;
      end
      if (out_wait > 0) begin
        out_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG);
        $display("hull_point_normalize_weld verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      hpnw_pkg::REG_SCALE_X: scl[0] = longint'($signed(val));
      hpnw_pkg::REG_SCALE_Y: scl[1] = longint'($signed(val));
      hpnw_pkg::REG_SCALE_Z: scl[2] = longint'($signed(val));
      hpnw_pkg::REG_TARGET:  tgt_size = val[30:0];
      hpnw_pkg::REG_WELD:    weld_dist = val[15:0];
      default: ;
    endcase
  endtask

  // Waits until every queued beat went in and every result came out.
  // Sampling at the falling edge sees the settled driver and predictor state.
  task automatic drain();
    while (vertex_queue.size() > 0 || in_valid || expected_points.size() > 0)
      @(negedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic hpnw_pkg::in_t make_vertex(logic [31:0] x, logic [31:0] y,
                                                logic [31:0] z, bit lst, bit none);
    hpnw_pkg::in_t b;
    b.vertex_x = x;
    b.vertex_y = y;
    b.vertex_z = z;
    b.last_vertex = lst;
    b.no_vertex = none;
    return b;
  endfunction

  // Random coordinate: mostly small so that welds and shrink both occur.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 20) - 10;
      2: return ($urandom_range(0, 200) - 100) << 16;
      default: return $urandom_range(0, 2000000) - 1000000;
    endcase
  endfunction

  task automatic queue_mesh(int n);
    for (int i = 0; i < n; i++)
      add_vertex(make_vertex(rand_coord(), rand_coord(), rand_coord(),
                             i == n - 1, $urandom_range(0, 15) == 0));
  endtask

  initial begin
    int sent;
    scl[0] = 65536; scl[1] = 65536; scl[2] = 65536;
    tgt_size = 655360;
    weld_dist = 7;
    clear_mesh();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, a weld pair, an ignored beat and an empty mesh.
    add_vertex(make_vertex(32'h7fffffff, 32'h80000000, 32'h0, 0, 0));
    add_vertex(make_vertex(32'h80000000, 32'h7fffffff, 32'hffffffff, 0, 0));
    add_vertex(make_vertex(32'd5, 32'd5, 32'd5, 0, 1));
    add_vertex(make_vertex(32'd0, 32'd0, 32'd0, 0, 0));
    add_vertex(make_vertex(32'd1, 32'd1, 32'd1, 0, 0));
    add_vertex(make_vertex(32'd3, 32'd0, 32'd0, 1, 0));
    add_vertex(make_vertex(32'd0, 32'd0, 32'd0, 1, 1));
    add_vertex(make_vertex(32'd10, 32'd20, 32'd30, 1, 0));
    drain();

    // Overflowing scale skips vertices; a zero target with an extent.
    write_reg(hpnw_pkg::REG_SCALE_X, 32'h7fffffff);
    write_reg(hpnw_pkg::REG_SCALE_Y, 32'h80000000);
    write_reg(hpnw_pkg::REG_TARGET, 32'd0);
    add_vertex(make_vertex(32'h00010000, 32'd1, 32'd1, 0, 0));
    add_vertex(make_vertex(32'd2, 32'd3, 32'd4, 0, 0));
    add_vertex(make_vertex(32'd1000, 32'd7, 32'd9, 1, 0));
    drain();

    // Store overflow: more than the store holds in one mesh.
    write_reg(hpnw_pkg::REG_SCALE_X, 32'd65536);
    write_reg(hpnw_pkg::REG_SCALE_Y, 32'd65536);
    write_reg(hpnw_pkg::REG_TARGET, 32'h7fffffff);
    write_reg(hpnw_pkg::REG_WELD, 32'd0);
    queue_mesh(70);
    drain();

    // Random meshes with the register settings redrawn between them.
    sent = 0;
    while (sent < 320) begin
      int n;
      case ($urandom_range(0, 3))
        0: write_reg(hpnw_pkg::REG_SCALE_Z, $urandom);
        1: write_reg(hpnw_pkg::REG_SCALE_Z, $urandom_range(0, 131072));
        default: write_reg(hpnw_pkg::REG_SCALE_Z, 32'd65536);
      endcase
      write_reg(hpnw_pkg::REG_SCALE_X, $urandom_range(0, 3) == 0 ? $urandom : 32'd65536);
      write_reg(hpnw_pkg::REG_SCALE_Y, $urandom_range(16384, 131072));
      write_reg(hpnw_pkg::REG_TARGET, $urandom_range(0, 1) ? $urandom_range(1, 2000000)
                                                            : ($urandom >> 1));
      write_reg(hpnw_pkg::REG_WELD,
                $urandom_range(0, 2) == 0 ? 32'hffff : $urandom_range(0, 40));
      n = $urandom_range(0, 5) == 0 ? $urandom_range(60, 70) : $urandom_range(1, 12);
      queue_mesh(n);
      sent += n;
      drain();
    end

    $display("%0d input beats in %0d meshes, %0d result beats checked, %0d errors",
             beats_in, meshes, beats_out, errors);
    if (errors == 0 && expected_points.size() == 0) begin
      $display("hull_point_normalize_weld verification clean");
    end else begin
      $display("hull_point_normalize_weld verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/hpnw_pkg.sv
design/hpnw_ram.sv
design/hpnw_div.sv
design/hpnw_cell.sv
design/hull_point_normalize_weld.sv
design/hpnw_checker.sv
dv/hull_point_normalize_weld_tb.sv
